// File: src/fppd_pkg.sv
// Package for the frustum plane point distance core.
// Holds action codes, controller state type, plane selection and arithmetic helpers.
// No dependencies.
package fppd_pkg;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_BUILD = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam int NUM_PLANES = 6;

   localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SQUARE,
      ST_SQRT,
      ST_DLOAD,
      ST_DIV,
      ST_WROW,
      ST_QUERY,
      ST_OUT
   } fppd_state_type;

   // Matrix column combined with column 3 for each plane.
   function automatic logic [1:0] plane_col(input logic [2:0] p);
      logic [1:0] c;
      case (p)
         3'd0: c = 2'd2;
         3'd1: c = 2'd0;
         3'd2: c = 2'd0;
         3'd3: c = 2'd1;
         3'd4: c = 2'd1;
         default: c = 2'd2;
      endcase
      return c;
   endfunction

   // High when the plane subtracts its column from column 3.
   function automatic logic plane_sub(input logic [2:0] p);
      logic s;
      case (p)
         3'd0: s = 1'b1;
         3'd1: s = 1'b1;
         3'd4: s = 1'b1;
         default: s = 1'b0;
      endcase
      return s;
   endfunction

   // Saturate a 33-bit signed sum to 32 bits.
   function automatic logic [31:0] sat33(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? S32_MIN : S32_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Magnitude of a signed 32-bit value.
   function automatic logic [31:0] mag32(input logic [31:0] v);
      logic [31:0] r;
      r = v[31] ? (32'd0 - v) : v;
      return r;
   endfunction

endpackage

// File: src/frustum_plane_point_distance_core.sv
// Top level of the frustum plane point distance core.
// Matrix store, plane builder (sqrt and divide units) and point query.
// Depends on fppd_pkg.
//
// Query timing: after a query's request transfer, one plane row is read from the plane
// memory each cycle, and the six rows pass through three pipeline stages before the
// result is offered on rsp_tvalid. A matrix write is done on its request transfer.
// A build fetches, squares, takes the square root of and divides each plane in turn, then
// writes its row; the square root and divider produce one result bit per cycle, and a
// zero-length plane skips the divides.
// Throughput: one item at a time; the next request transfer is taken the cycle after the
// result is gone.
// Reset: synchronous, active high; both stores read as zero and the degenerate flag clears.
module frustum_plane_point_distance_core
   import fppd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action
   input  logic [1:0]   req_tuser,
   // element_index[3:0], element_value[35:4], point_x[67:36], point_y[99:68],
   // point_z[131:100], zero fill[135:132]
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // degenerate
   output logic [0:0]   rsp_tuser,
   // min_distance[31:0]
   output logic [31:0]  rsp_tdata
);

   // Dividend width of the normalizing divide: magnitude shifted up by the fraction bits.
   localparam int DVW = 32 + FRAC_BITS;
   localparam int DCW = $clog2(DVW);
   // Width of the exact plane distance sum.
   localparam int SW = 66;

   fppd_state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [2:0] plane_ff, plane_in;
   logic [1:0] cj_ff, cj_in;
   logic       deg_ff, deg_in;
   logic       pvalid_ff, pvalid_in;
   logic [15:0] mvalid_ff;

   logic req_xfer;
   logic [1:0] action;
   logic [3:0] step_m1;

   // Matrix memory.
   logic [31:0] mat_mem [16];
   logic        mat_rd_en;
   logic [3:0]  mat_rd_addr;
   logic [31:0] mat_q_ff;
   logic        mat_qv_ff;
   logic [31:0] mat_rd;

   // Plane memory, one row of four components per plane.
   logic [127:0] pl_mem [NUM_PLANES];
   logic         pl_rd_en;
   logic         pl_wr_en;
   logic [127:0] pl_q_ff;
   logic [127:0] pl_rd;

   // Build datapath.
   logic [31:0] a_ff;
   logic [31:0] comp_ff [4];
   logic [31:0] row_ff [4];
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [63:0] res_ff;
   logic [4:0]  sq_cnt_ff;
   logic [31:0] len_ff;
   logic [63:0] sq_bit;
   logic [64:0] sq_trial;
   logic        sq_ge;
   logic [63:0] sq_res_nx;
   logic [DVW-1:0] dvd_ff;
   logic [DVW-1:0] quo_ff;
   logic [31:0]    rem_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic [32:0]    rem_sh;
   logic           div_ge;
   logic [32:0]    rem_sub;
   logic [DVW-1:0] quo_nx;
   logic [31:0]    quo_sat;
   logic [32:0]    fetch_sum;

   // Query datapath.
   logic [31:0] pt_ff [3];
   logic signed [63:0] qp_ff [3];
   logic [31:0] qw_ff;
   logic signed [SW-1:0] qsum;
   logic signed [SW-1:0] qshift;
   logic signed [31:0]   dist_ff;
   logic signed [31:0]   best_ff;

   assign req_xfer = req_tvalid && req_tready;
   assign action   = req_tuser;
   assign step_m1  = step_ff - 4'd1;

   // Controller.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         plane_ff  <= '0;
         cj_ff     <= '0;
         deg_ff    <= 1'b0;
         pvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         plane_ff  <= plane_in;
         cj_ff     <= cj_in;
         deg_ff    <= deg_in;
         pvalid_ff <= pvalid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      plane_in    = plane_ff;
      cj_in       = cj_ff;
      deg_in      = deg_ff;
      pvalid_in   = pvalid_ff;
      mat_rd_en   = 1'b0;
      mat_rd_addr = {step_ff[2:1], step_ff[0] ? plane_col(plane_ff) : 2'd3};
      pl_rd_en    = 1'b0;
      pl_wr_en    = 1'b0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (action)
                  ACT_BUILD: begin
                     deg_in   = 1'b0;
                     plane_in = '0;
                     step_in  = '0;
                     state_in = ST_FETCH;
                  end
                  ACT_QUERY: begin
                     step_in  = '0;
                     state_in = ST_QUERY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            mat_rd_en = (step_ff < 4'd8);
            if (step_ff == 4'd8) begin
               step_in  = '0;
               state_in = ST_SQUARE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_SQUARE: begin
            if (step_ff == 4'd3) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_SQRT: begin
            if (sq_cnt_ff == 5'd0) begin
               if (sq_res_nx[31:0] == 32'd0) begin
                  deg_in   = 1'b1;
                  state_in = ST_WROW;
               end else begin
                  cj_in    = 2'd0;
                  state_in = ST_DLOAD;
               end
            end
         end
         ST_DLOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               if (cj_ff == 2'd3) begin
                  state_in = ST_WROW;
               end else begin
                  cj_in    = cj_ff + 2'd1;
                  state_in = ST_DLOAD;
               end
            end
         end
         ST_WROW: begin
            pl_wr_en = 1'b1;
            if (plane_ff == 3'(NUM_PLANES - 1)) begin
               pvalid_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               plane_in = plane_ff + 3'd1;
               step_in  = '0;
               state_in = ST_FETCH;
            end
         end
         ST_QUERY: begin
            pl_rd_en = (step_ff < 4'(NUM_PLANES));
            if (step_ff == 4'd8) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Matrix memory; a valid bit per entry makes unwritten entries read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= '0;
      end else if (req_xfer && action == ACT_WRITE) begin
         mvalid_ff[req_tdata[3:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && action == ACT_WRITE) begin
         mat_mem[req_tdata[3:0]] <= req_tdata[35:4];
      end
      if (mat_rd_en) begin
         mat_q_ff  <= mat_mem[mat_rd_addr];
         mat_qv_ff <= mvalid_ff[mat_rd_addr];
      end
   end

   assign mat_rd = mat_qv_ff ? mat_q_ff : 32'd0;

   // Plane memory; rows read as zero until the first build completes.
   always_ff @(posedge clock) begin
      if (pl_wr_en) begin
         pl_mem[plane_ff] <= {row_ff[3], row_ff[2], row_ff[1], row_ff[0]};
      end
      if (pl_rd_en) begin
         pl_q_ff <= pl_mem[step_ff[2:0]];
      end
   end

   assign pl_rd = pvalid_ff ? pl_q_ff : 128'd0;

   // Build arithmetic.
   assign fetch_sum = plane_sub(plane_ff)
                    ? ({a_ff[31], a_ff} - {mat_rd[31], mat_rd})
                    : ({a_ff[31], a_ff} + {mat_rd[31], mat_rd});

   assign sq_bit   = 64'd1 << {sq_cnt_ff, 1'b0};
   assign sq_trial = {1'b0, res_ff} + {1'b0, sq_bit};
   assign sq_ge    = ({1'b0, acc_ff} >= sq_trial);
   assign sq_res_nx = sq_ge ? ((res_ff >> 1) + sq_bit) : (res_ff >> 1);

   assign rem_sh  = {rem_ff, dvd_ff[DVW-1]};
   assign div_ge  = (rem_sh >= {1'b0, len_ff});
   assign rem_sub = rem_sh - {1'b0, len_ff};
   assign quo_nx  = {quo_ff[DVW-2:0], div_ge};

   // Apply the sign and clamp the quotient to the signed 32-bit range.
   always_comb begin
      if (comp_ff[cj_ff][31]) begin
         if (quo_nx > DVW'(33'h1_0000_0000 >> 1)) begin
            quo_sat = S32_MIN;
         end else begin
            quo_sat = 32'd0 - quo_nx[31:0];
         end
      end else begin
         if (quo_nx > DVW'(S32_MAX)) begin
            quo_sat = S32_MAX;
         end else begin
            quo_sat = quo_nx[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_FETCH: begin
            if (step_ff == 4'd0) begin
               acc_ff <= '0;
            end else if (step_ff[0]) begin
               a_ff <= mat_rd;
            end else begin
               comp_ff[step_m1[2:1]] <= sat33(fetch_sum);
            end
         end
         ST_SQUARE: begin
            if (step_ff < 4'd3) begin
               prod_ff <= mag32(comp_ff[step_ff[1:0]]) * mag32(comp_ff[step_ff[1:0]]);
            end
            if (step_ff != 4'd0) begin
               acc_ff <= acc_ff + prod_ff;
            end
            if (step_ff == 4'd3) begin
               res_ff    <= '0;
               sq_cnt_ff <= 5'd31;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               acc_ff <= acc_ff - sq_trial[63:0];
            end
            res_ff    <= sq_res_nx;
            sq_cnt_ff <= sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == 5'd0) begin
               len_ff <= sq_res_nx[31:0];
               // Zero-length normal: xyz clear, w pushed to its signed limit unless it is zero.
               row_ff[0] <= 32'd0;
               row_ff[1] <= 32'd0;
               row_ff[2] <= 32'd0;
               if (comp_ff[3] == 32'd0) begin
                  row_ff[3] <= 32'd0;
               end else begin
                  row_ff[3] <= comp_ff[3][31] ? S32_MIN : S32_MAX;
               end
            end
         end
         ST_DLOAD: begin
            dvd_ff     <= {mag32(comp_ff[cj_ff]), {FRAC_BITS{1'b0}}};
            rem_ff     <= '0;
            quo_ff     <= '0;
            div_cnt_ff <= DCW'(DVW - 1);
         end
         ST_DIV: begin
            rem_ff     <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
            quo_ff     <= quo_nx;
            dvd_ff     <= {dvd_ff[DVW-2:0], 1'b0};
            div_cnt_ff <= div_cnt_ff - DCW'(1);
            if (div_cnt_ff == '0) begin
               row_ff[cj_ff] <= quo_sat;
            end
         end
         default: begin
         end
      endcase
   end

   // Query pipeline: read row, multiply, sum and floor shift, running minimum.
   assign qsum = SW'(qp_ff[0]) + SW'(qp_ff[1]) + SW'(qp_ff[2])
               + (SW'(signed'(qw_ff)) <<< FRAC_BITS);
   assign qshift = qsum >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (req_xfer && action == ACT_QUERY) begin
         pt_ff[0] <= req_tdata[67:36];
         pt_ff[1] <= req_tdata[99:68];
         pt_ff[2] <= req_tdata[131:100];
      end
      if (state_ff == ST_QUERY) begin
         if (step_ff >= 4'd1 && step_ff <= 4'd6) begin
            qp_ff[0] <= signed'(pl_rd[31:0])  * signed'(pt_ff[0]);
            qp_ff[1] <= signed'(pl_rd[63:32]) * signed'(pt_ff[1]);
            qp_ff[2] <= signed'(pl_rd[95:64]) * signed'(pt_ff[2]);
            qw_ff    <= pl_rd[127:96];
         end
         if (step_ff >= 4'd2 && step_ff <= 4'd7) begin
            if (qshift > SW'(signed'(S32_MAX))) begin
               dist_ff <= signed'(S32_MAX);
            end else if (qshift < SW'(signed'(S32_MIN))) begin
               dist_ff <= signed'(S32_MIN);
            end else begin
               dist_ff <= qshift[31:0];
            end
         end
         if (step_ff >= 4'd3 && step_ff <= 4'd8) begin
            if (step_ff == 4'd3 || dist_ff < best_ff) begin
               best_ff <= dist_ff;
            end
         end
      end
   end

   assign rsp_tdata = best_ff;
   assign rsp_tuser = deg_ff;

   // The divider remainder always stays below the divisor.
   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < len_ff)
      else $error("divide remainder not below length");

   // A division only starts with a nonzero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DLOAD |-> len_ff != 32'd0)
      else $error("divide started on zero length");

   // A build clears the degenerate flag on the transfer that starts it.
   a_build_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && action == ACT_BUILD |=> !deg_ff)
      else $error("degenerate flag not cleared by build");

   // No result is offered while a new request can be taken.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result overlap");

   // A query result never appears on the cycle after its request.
   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer && action == ACT_QUERY |=> !rsp_tvalid)
      else $error("query result too early");

endmodule
